### hdl/bbc_pkg.sv
// Package for the block buffer cache tag and replacement manager.
// Holds the slot record type, command and result codes and link constants.
// No dependencies.
`default_nettype none

package bbc_pkg;

  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_REL   = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic [1:0] K_GRANT = 2'd0;
  localparam logic [1:0] K_WB    = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_NOBUF = 2'd3;

  localparam logic [6:0]  NO_LINK   = 7'd127;
  localparam logic [31:0] EMPTY_TAG = 32'hffff_ffff;
  localparam logic [7:0]  CNT_MAX   = 8'hff;

  typedef struct packed {
    logic [31:0] blk;
    logic [7:0]  dev;
    logic [7:0]  cnt;
    logic        dirty;
  } rec_t;

  localparam rec_t REC_RESET = '{blk: EMPTY_TAG, dev: 8'd0, cnt: 8'd0, dirty: 1'b0};

endpackage

`default_nettype wire

### hdl/block_buffer_cache_lru.sv
// Block buffer cache tag and replacement manager: associative lookup, LRU list
// of unused slots held in slot, next and prev memories. Depends on bbc_pkg.
// A get runs a sequential tag scan, one memory read per cycle; a flush reads
// each slot in turn on the shared read port. Get, release and flush can be held
// by output stalls. One item at a time. Sync reset: slots empty, list in slot
// order; no clearing pass, per-slot valid bits stand in for the reset contents.
`default_nettype none

module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  dev,
  input  wire logic [31:0] block,
  input  wire logic [5:0]  buf_index,
  input  wire logic        keep_longer,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       kind,
  output logic [5:0]       slot,
  output logic [7:0]       event_dev,
  output logic [31:0]      event_block,
  output logic             hit,
  output logic             last
);
  import bbc_pkg::*;

  localparam int SW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam logic [6:0] NB = 7'(NUM_BUFFERS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_BUFFERS - 1);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_SCAN  = 19'h00002,
    S_LRD   = 19'h00004,
    S_LA    = 19'h00008,
    S_LB    = 19'h00010,
    S_WB    = 19'h00020,
    S_UL1   = 19'h00040,
    S_UL2   = 19'h00080,
    S_READ  = 19'h00100,
    S_GRANT = 19'h00200,
    S_NOBUF = 19'h00400,
    S_REL   = 19'h00800,
    S_LK1   = 19'h01000,
    S_LK2   = 19'h02000,
    S_RWB   = 19'h04000,
    S_MARK  = 19'h08000,
    S_FRD   = 19'h10000,
    S_FCHK  = 19'h20000,
    S_FEND  = 19'h40000
  } state_t;

  rec_t       rec_mem [NUM_BUFFERS];
  logic [6:0] nxt_mem [NUM_BUFFERS];
  logic [6:0] prv_mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] rec_vld, nxt_vld, prv_vld;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic pend, pend_next;
  logic [SW-1:0] cur_slot, cur_slot_next;
  rec_t cur, cur_next;
  logic [6:0] lnk_n, lnk_n_next, lnk_p, lnk_p_next;
  logic wb, wb_next, miss, miss_next;
  logic [6:0] head, head_next, tail, tail_next;
  logic hold_vld, hold_vld_next;
  logic [SW-1:0] hold_slot, hold_slot_next;
  logic [7:0] hold_dev, hold_dev_next;
  logic [31:0] hold_blk, hold_blk_next;
  logic [7:0] dev_q;
  logic [31:0] blk_q;
  logic keep_q;

  logic [SW-1:0] ra, rd_slot;
  rec_t rec_raw, rd_rec;
  logic [6:0] nxt_raw, prv_raw, rd_next, rd_prev;
  logic rd_rvld, rd_nvld, rd_pvld;

  logic rec_we, nxt_we, prv_we;
  logic [SW-1:0] rec_wa, nxt_wa, prv_wa;
  rec_t rec_wd;
  logic [6:0] nxt_wd, prv_wd;

  logic emit, out_free, e_hit, e_last;
  logic [1:0] e_kind;
  logic [SW-1:0] e_slot;
  logic [7:0] e_dev;
  logic [31:0] e_blk;
  logic accept, in_range, match;
  logic [6:0] s7;

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign in_range = (7'(buf_index) < NB);
  assign s7 = 7'(cur_slot);

  assign rd_rec = rd_rvld ? rec_raw : REC_RESET;
  assign rd_next = rd_nvld ? nxt_raw : ((rd_slot == LAST_SLOT) ? NO_LINK : 7'(rd_slot) + 7'd1);
  assign rd_prev = rd_pvld ? prv_raw : ((rd_slot == '0) ? NO_LINK : 7'(rd_slot) - 7'd1);
  assign match = (rd_rec.blk != EMPTY_TAG) && (rd_rec.blk == blk_q) && (rd_rec.dev == dev_q);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pend_next = 1'b0;
    cur_slot_next = cur_slot;
    cur_next = cur;
    lnk_n_next = lnk_n;
    lnk_p_next = lnk_p;
    wb_next = wb;
    miss_next = miss;
    head_next = head;
    tail_next = tail;
    hold_vld_next = hold_vld;
    hold_slot_next = hold_slot;
    hold_dev_next = hold_dev;
    hold_blk_next = hold_blk;
    ra = cur_slot;
    rec_we = 1'b0;
    rec_wa = cur_slot;
    rec_wd = cur;
    nxt_we = 1'b0;
    nxt_wa = cur_slot;
    nxt_wd = NO_LINK;
    prv_we = 1'b0;
    prv_wa = cur_slot;
    prv_wd = NO_LINK;
    emit = 1'b0;
    e_kind = K_WB;
    e_slot = cur_slot;
    e_dev = cur.dev;
    e_blk = cur.blk;
    e_hit = 1'b0;
    e_last = 1'b0;
    case (state)
      S_IDLE: begin
        ra = buf_index[SW-1:0];
        if (req_valid) begin
          cur_slot_next = buf_index[SW-1:0];
          case (cmd)
            CMD_GET: begin
              cnt_next = '0;
              state_next = S_SCAN;
            end
            CMD_REL: if (in_range) state_next = S_REL;
            CMD_MARK: if (in_range) state_next = S_MARK;
            default: begin
              cnt_next = '0;
              hold_vld_next = 1'b0;
              state_next = S_FRD;
            end
          endcase
        end
      end
      S_SCAN: begin
        ra = cnt[SW-1:0];
        cnt_next = cnt + CW'(1);
        pend_next = 1'b1;
        if (pend) begin
          if (match) begin
            cur_slot_next = rd_slot;
            miss_next = 1'b0;
            state_next = S_LRD;
          end else if (rd_slot == LAST_SLOT) begin
            if (head < NB) begin
              cur_slot_next = head[SW-1:0];
              miss_next = 1'b1;
              state_next = S_LRD;
            end else begin
              state_next = S_NOBUF;
            end
          end
        end
      end
      S_LRD: state_next = S_LA;
      S_LA: begin
        cur_next = rd_rec;
        lnk_n_next = rd_next;
        lnk_p_next = rd_prev;
        state_next = S_LB;
      end
      S_LB: begin
        rec_we = 1'b1;
        if (miss) begin
          rec_wd = '{blk: blk_q, dev: dev_q, cnt: 8'd1, dirty: 1'b0};
          wb_next = cur.dirty;
          state_next = S_WB;
        end else if (cur.cnt != 8'd0) begin
          rec_wd.cnt = (cur.cnt == CNT_MAX) ? CNT_MAX : cur.cnt + 8'd1;
          state_next = S_GRANT;
        end else begin
          rec_wd.cnt = 8'd1;
          rec_wd.dirty = 1'b0;
          wb_next = cur.dirty;
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (!wb) begin
          state_next = S_UL1;
        end else if (out_free) begin
          emit = 1'b1;
          state_next = S_UL1;
        end
      end
      S_UL1: begin
        if (lnk_p < NB) begin
          nxt_we = 1'b1;
          nxt_wa = lnk_p[SW-1:0];
          nxt_wd = lnk_n;
        end else begin
          head_next = lnk_n;
        end
        if (lnk_n < NB) begin
          prv_we = 1'b1;
          prv_wa = lnk_n[SW-1:0];
          prv_wd = lnk_p;
        end else begin
          tail_next = lnk_p;
        end
        state_next = S_UL2;
      end
      S_UL2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        state_next = miss ? S_READ : S_GRANT;
      end
      S_READ: begin
        e_kind = K_READ;
        e_dev = dev_q;
        e_blk = blk_q;
        if (out_free) begin
          emit = 1'b1;
          state_next = S_GRANT;
        end
      end
      S_GRANT: begin
        e_kind = K_GRANT;
        e_dev = dev_q;
        e_blk = blk_q;
        e_hit = !miss;
        e_last = 1'b1;
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NOBUF: begin
        e_kind = K_NOBUF;
        e_slot = '0;
        e_dev = dev_q;
        e_blk = blk_q;
        e_last = 1'b1;
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REL: begin
        cur_next = rd_rec;
        rec_wd = rd_rec;
        if (rd_rec.cnt == 8'd0) begin
          state_next = S_IDLE;
        end else if (rd_rec.cnt != 8'd1) begin
          rec_we = 1'b1;
          rec_wd.cnt = rd_rec.cnt - 8'd1;
          state_next = S_IDLE;
        end else begin
          rec_we = 1'b1;
          rec_wd.cnt = 8'd0;
          rec_wd.dirty = 1'b0;
          state_next = S_LK1;
        end
      end
      S_LK1: begin
        nxt_we = 1'b1;
        nxt_wd = keep_q ? NO_LINK : head;
        prv_we = 1'b1;
        prv_wd = keep_q ? tail : NO_LINK;
        state_next = S_LK2;
      end
      S_LK2: begin
        if (keep_q) begin
          if (tail < NB) begin
            nxt_we = 1'b1;
            nxt_wa = tail[SW-1:0];
            nxt_wd = s7;
          end else begin
            head_next = s7;
          end
          tail_next = s7;
        end else begin
          if (head < NB) begin
            prv_we = 1'b1;
            prv_wa = head[SW-1:0];
            prv_wd = s7;
          end else begin
            tail_next = s7;
          end
          head_next = s7;
        end
        state_next = S_RWB;
      end
      S_RWB: begin
        e_last = 1'b1;
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        rec_we = 1'b1;
        rec_wd = rd_rec;
        rec_wd.dirty = 1'b1;
        state_next = S_IDLE;
      end
      S_FRD: begin
        ra = cnt[SW-1:0];
        state_next = S_FCHK;
      end
      S_FCHK: begin
        ra = cnt[SW-1:0];
        e_slot = hold_slot;
        e_dev = hold_dev;
        e_blk = hold_blk;
        if (rd_rec.dev == dev_q && rd_rec.dirty) begin
          if (!hold_vld || out_free) begin
            emit = hold_vld;
            hold_vld_next = 1'b1;
            hold_slot_next = rd_slot;
            hold_dev_next = rd_rec.dev;
            hold_blk_next = rd_rec.blk;
            rec_we = 1'b1;
            rec_wa = rd_slot;
            rec_wd = rd_rec;
            rec_wd.dirty = 1'b0;
            cnt_next = cnt + CW'(1);
            state_next = (cnt[SW-1:0] == LAST_SLOT) ? S_FEND : S_FRD;
          end
        end else begin
          cnt_next = cnt + CW'(1);
          state_next = (cnt[SW-1:0] == LAST_SLOT) ? S_FEND : S_FRD;
        end
      end
      S_FEND: begin
        e_slot = hold_slot;
        e_dev = hold_dev;
        e_blk = hold_blk;
        e_last = 1'b1;
        if (!hold_vld) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    rec_raw <= rec_mem[ra];
    nxt_raw <= nxt_mem[ra];
    prv_raw <= prv_mem[ra];
    rd_rvld <= rec_vld[ra];
    rd_nvld <= nxt_vld[ra];
    rd_pvld <= prv_vld[ra];
    rd_slot <= ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= '0;
      nxt_vld <= '0;
      prv_vld <= '0;
    end else begin
      if (rec_we) rec_vld[rec_wa] <= 1'b1;
      if (nxt_we) nxt_vld[nxt_wa] <= 1'b1;
      if (prv_we) prv_vld[prv_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend <= 1'b0;
      hold_vld <= 1'b0;
      head <= 7'd0;
      tail <= 7'(NUM_BUFFERS - 1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend <= pend_next;
      hold_vld <= hold_vld_next;
      head <= head_next;
      tail <= tail_next;
      if (emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    cur_slot <= cur_slot_next;
    cur <= cur_next;
    lnk_n <= lnk_n_next;
    lnk_p <= lnk_p_next;
    wb <= wb_next;
    miss <= miss_next;
    hold_slot <= hold_slot_next;
    hold_dev <= hold_dev_next;
    hold_blk <= hold_blk_next;
    if (accept) begin
      dev_q <= dev;
      blk_q <= block;
      keep_q <= keep_longer;
    end
    if (emit) begin
      kind <= e_kind;
      slot <= 6'(e_slot);
      event_dev <= e_dev;
      event_block <= e_blk;
      hit <= e_hit;
      last <= e_last;
    end
  end

endmodule

`default_nettype wire
